@@ rtl/core/threshold_layer_compositor_macros.svh @@
// Assertion macros shared by the threshold layer compositor RTL.
`ifndef THRESHOLD_LAYER_COMPOSITOR_MACROS_SVH
`define THRESHOLD_LAYER_COMPOSITOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TLC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("threshold_layer_compositor: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("threshold_layer_compositor: next-cycle check failed");

`endif

@@ rtl/core/tlc_pkg.sv @@
// Package with shared types and constants of the threshold layer compositor.
package tlc_pkg;

  localparam int unsigned VAL_BITS = 16;
  localparam int unsigned THR_BITS = 17;
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam int unsigned CFG_DATA_BITS = 17;

  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTPUT_MAX = 1'd1;

  localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 17'd32768;
  localparam logic [VAL_BITS-1:0] OUTPUT_MAX_RESET = 16'd255;

  typedef struct packed {
    logic [VAL_BITS-1:0] sample;
    logic [VAL_BITS-1:0] layer_max;
    logic                use_max;
    logic                fallback;
    logic                frame_end;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

@@ rtl/core/tlc_layer_if.sv @@
// Channel interface that carries one layer sample word per handshake.
interface tlc_layer_if;
  import tlc_pkg::*;

  logic                valid;
  logic                ready;
  logic [VAL_BITS-1:0] sample;
  logic                present;
  logic [VAL_BITS-1:0] layer_max;
  logic                last_layer;
  logic                frame_end;

  modport source (output valid, sample, present, layer_max, last_layer, frame_end,
                  input ready);
  modport sink (input valid, sample, present, layer_max, last_layer, frame_end,
                output ready);
endinterface

@@ rtl/core/tlc_pixel_if.sv @@
// Channel interface that carries one composited pixel word per handshake.
interface tlc_pixel_if;
  import tlc_pkg::*;

  logic                valid;
  logic                ready;
  logic [VAL_BITS-1:0] pixel_value;
  logic                from_fallback;
  logic                end_of_frame;

  modport source (output valid, pixel_value, from_fallback, end_of_frame, input ready);
  modport sink (input valid, pixel_value, from_fallback, end_of_frame, output ready);
endinterface

@@ rtl/core/tlc_cfg_if.sv @@
// Register write channel interface of the threshold layer compositor.
interface tlc_cfg_if;
  import tlc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/tlc_front.sv @@
// Front end: accepts layer words, runs the threshold test and queues one job per pixel.
module tlc_front #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [tlc_pkg::THR_BITS-1:0]        threshold_q16,
  input  tlc_pkg::q_status_t                  q_status,
  output logic                                push,
  output tlc_pkg::job_t                       push_job,
  tlc_layer_if.sink                           layers
);
  import tlc_pkg::*;

  localparam logic [VAL_BITS:0] MASK_WIDE = (17'd1 << SAMPLE_BITS) - 17'd1;
  localparam logic [VAL_BITS-1:0] SAMPLE_MASK = MASK_WIDE[VAL_BITS-1:0];

  logic                decided;
  logic [VAL_BITS-1:0] held_sample;
  logic [VAL_BITS-1:0] held_max;

  logic                accept;
  logic [VAL_BITS-1:0] s_eff;
  logic [32:0]         lhs;
  logic [32:0]         rhs;
  logic                takes;

  assign layers.ready = !q_status.full;
  assign accept = layers.valid && layers.ready;
  assign s_eff = layers.sample & SAMPLE_MASK;
  assign lhs = {1'b0, s_eff, 16'b0};
  assign rhs = 33'(threshold_q16) * 33'(layers.layer_max);
  assign takes = !decided && layers.present && (lhs < rhs);

  always_comb begin
    push = accept && layers.last_layer;
    push_job.frame_end = layers.frame_end;
    if (decided) begin
      push_job.sample = held_sample;
      push_job.layer_max = held_max;
      push_job.use_max = 1'b0;
      push_job.fallback = 1'b0;
    end else if (takes) begin
      push_job.sample = s_eff;
      push_job.layer_max = layers.layer_max;
      push_job.use_max = 1'b0;
      push_job.fallback = 1'b0;
    end else begin
      push_job.sample = s_eff;
      push_job.layer_max = layers.layer_max;
      push_job.use_max = !layers.present;
      push_job.fallback = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decided <= 1'b0;
    end else if (accept) begin
      if (layers.last_layer) begin
        decided <= 1'b0;
      end else if (takes) begin
        decided <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && takes) begin
      held_sample <= s_eff;
      held_max <= layers.layer_max;
    end
  end

endmodule

@@ rtl/core/tlc_queue.sv @@
// Small job queue between the front end and the scaling back end.
module tlc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tlc_pkg::job_t      push_job,
  input  logic               pop,
  output tlc_pkg::job_t      pop_job,
  output tlc_pkg::q_status_t status
);
  import tlc_pkg::*;

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  job_t                entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign status.full = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

@@ rtl/core/tlc_back.sv @@
// Back end: bit-serial divide scales the deciding sample, else output_max; holds result.
module tlc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [tlc_pkg::VAL_BITS-1:0] output_max,
  input  tlc_pkg::q_status_t           q_status,
  input  tlc_pkg::job_t                job,
  output logic                         pop,
  tlc_pixel_if.source                  pixels
);
  import tlc_pkg::*;

  localparam int unsigned STEP_BITS = $clog2(VAL_BITS);
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(VAL_BITS - 1);

  back_state_t         state;
  back_state_t         state_next;

  logic [VAL_BITS-1:0]  divisor;
  logic [VAL_BITS-1:0]  rem;
  logic [VAL_BITS-1:0]  low_bits;
  logic [VAL_BITS-1:0]  quo;
  logic [STEP_BITS-1:0] step;
  logic [VAL_BITS-1:0]  value;
  logic                 fallback;
  logic                 fend;

  logic                   direct;
  logic [2*VAL_BITS-1:0]  product;
  logic [VAL_BITS:0]      trial;
  logic                   qbit;
  logic [VAL_BITS:0]      trial_diff;

  assign direct = job.use_max || (job.layer_max == '0) || (job.sample >= job.layer_max);
  assign product = (2*VAL_BITS)'(output_max) * (2*VAL_BITS)'(job.sample);
  assign trial = {rem, low_bits[VAL_BITS-1]};
  assign qbit = (trial >= {1'b0, divisor});
  assign trial_diff = trial - {1'b0, divisor};

  assign pixels.valid = (state == B_OUT);
  assign pixels.pixel_value = value;
  assign pixels.from_fallback = fallback;
  assign pixels.end_of_frame = fend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          state_next = direct ? B_OUT : B_DIV;
        end
      end
      B_DIV: begin
        if (step == LAST_STEP) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (pixels.ready) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        fallback <= job.fallback;
        fend <= job.frame_end;
        divisor <= job.layer_max;
        rem <= product[2*VAL_BITS-1:VAL_BITS];
        low_bits <= product[VAL_BITS-1:0];
        step <= '0;
        value <= output_max;
      end
      B_DIV: begin
        rem <= qbit ? trial_diff[VAL_BITS-1:0] : trial[VAL_BITS-1:0];
        low_bits <= {low_bits[VAL_BITS-2:0], 1'b0};
        quo <= {quo[VAL_BITS-2:0], qbit};
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          value <= {quo[VAL_BITS-2:0], qbit};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/threshold_layer_compositor.sv @@
// Top level of the threshold layer compositor: registers, front end, queue and back end.
// Layer words are taken at one per cycle while the job queue has room.
// A pixel whose value needs scaling passes the back end's load, its serial divider (one quotient
// bit per step) and output; other pixels go from load straight to output.
// Synchronous reset clears the queue, the pixel state and sets both registers to defaults.
`include "threshold_layer_compositor_macros.svh"

module threshold_layer_compositor #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input logic        clk,
  input logic        rst,
  tlc_layer_if.sink  layers,
  tlc_pixel_if.source pixels,
  tlc_cfg_if.sink    cfg
);
  import tlc_pkg::*;

  logic [THR_BITS-1:0] threshold_q16;
  logic [VAL_BITS-1:0] output_max;

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  job_t      push_job;
  job_t      pop_job;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_q16 <= THRESHOLD_RESET;
      output_max <= OUTPUT_MAX_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_THRESHOLD: threshold_q16 <= cfg.data;
        REG_OUTPUT_MAX: output_max <= cfg.data[VAL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  tlc_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .threshold_q16 (threshold_q16),
    .q_status      (q_status),
    .push          (q_push),
    .push_job      (push_job),
    .layers        (layers)
  );

  tlc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  tlc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .output_max (output_max),
    .q_status   (q_status),
    .job        (pop_job),
    .pop        (q_pop),
    .pixels     (pixels)
  );

  `TLC_ASSERT_NOW(a_value_saturated, clk, rst, pixels.valid, pixels.pixel_value <= output_max)
  `TLC_ASSERT_NOW(a_pop_not_empty, clk, rst, q_pop, !q_status.empty)
  `TLC_ASSERT_NOW(a_push_not_full, clk, rst, q_push, !q_status.full)
  `TLC_ASSERT_NEXT(a_push_fills, clk, rst, q_push && !q_pop, !q_status.empty)

endmodule

@@ sim/tlc_compositor_checker.sv @@
// Checker that watches the compositor's channels, predicts pixel words and compares them.
`timescale 1ns / 1ps

module tlc_compositor_checker (
  input  logic  clk,
  input  logic  rst,
  tlc_layer_if  lay,
  tlc_pixel_if  pix,
  tlc_cfg_if    cfg,
  output int    errors,
  output int    pending,
  output int    pixels_checked
);
  import tlc_pkg::*;

  typedef struct packed {
    logic [VAL_BITS-1:0] value;
    logic                fallback;
    logic                eof;
  } pixel_word_t;

  pixel_word_t         expected_pixels[$];
  logic [THR_BITS-1:0] threshold;
  logic [VAL_BITS-1:0] out_max;
  logic                pixel_decided;
  logic [VAL_BITS-1:0] decided_value;

  function automatic logic [VAL_BITS-1:0] scaled_value(input logic [VAL_BITS-1:0] s,
                                                       input logic [VAL_BITS-1:0] mx,
                                                       input logic [VAL_BITS-1:0] om);
    logic [31:0] q;
    if (mx == 0) begin
      return om;
    end
    q = (32'(om) * 32'(s)) / 32'(mx);
    if (q > 32'(om)) begin
      q = 32'(om);
    end
    return q[VAL_BITS-1:0];
  endfunction

  function automatic logic under_threshold(input logic [VAL_BITS-1:0] s,
                                           input logic [VAL_BITS-1:0] mx,
                                           input logic [THR_BITS-1:0] thr);
    if (mx == 0) begin
      return 1'b0;
    end
    return (34'(s) << 16) < (34'(thr) * 34'(mx));
  endfunction

  always @(posedge clk) begin
    pixel_word_t want;
    if (rst) begin
      threshold = THRESHOLD_RESET;
      out_max = OUTPUT_MAX_RESET;
      pixel_decided = 1'b0;
      decided_value = '0;
      expected_pixels.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_THRESHOLD) begin
          threshold = cfg.data[THR_BITS-1:0];
        end else if (cfg.index == REG_OUTPUT_MAX) begin
          out_max = cfg.data[VAL_BITS-1:0];
        end
      end
      if (pix.valid && pix.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel word %0d arrived with no pixel expected", pix.pixel_value);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked++;
          if (pix.pixel_value !== want.value) begin
            $error("pixel_value: expected %0d, got %0d", want.value, pix.pixel_value);
            errors++;
          end
          if (pix.from_fallback !== want.fallback) begin
            $error("from_fallback: expected %0d, got %0d", want.fallback, pix.from_fallback);
            errors++;
          end
          if (pix.end_of_frame !== want.eof) begin
            $error("end_of_frame: expected %0d, got %0d", want.eof, pix.end_of_frame);
            errors++;
          end
        end
      end
      if (lay.valid && lay.ready) begin
        if (!pixel_decided && lay.present &&
            under_threshold(lay.sample, lay.layer_max, threshold)) begin
          pixel_decided = 1'b1;
          decided_value = scaled_value(lay.sample, lay.layer_max, out_max);
        end
        if (lay.last_layer) begin
          want.eof = lay.frame_end;
          if (pixel_decided) begin
            want.value = decided_value;
            want.fallback = 1'b0;
          end else begin
            want.value = lay.present ? scaled_value(lay.sample, lay.layer_max, out_max)
                                     : out_max;
            want.fallback = 1'b1;
          end
          expected_pixels.push_back(want);
          pixel_decided = 1'b0;
          decided_value = '0;
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

@@ sim/tb_threshold_layer_compositor.sv @@
// Testbench top for the threshold layer compositor: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module tb_threshold_layer_compositor;
  import tlc_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_WORDS = 140;
  localparam int DRAIN_CYCLES = 24;

  logic clk = 1'b0;
  logic rst;
  int   err_count;
  int   pending_count;
  int   checked_count;
  int   words_sent;
  int   send_idle;
  int   recv_idle;
  int   frame_left;
  bit   pixel_open;
  bit   stall_req;

  tlc_layer_if lay ();
  tlc_pixel_if pix ();
  tlc_cfg_if   cfg_ch ();

  threshold_layer_compositor DUT (
    .clk    (clk),
    .rst    (rst),
    .layers (lay),
    .pixels (pix),
    .cfg    (cfg_ch)
  );

  tlc_compositor_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .lay            (lay),
    .pix            (pix),
    .cfg            (cfg_ch),
    .errors         (err_count),
    .pending        (pending_count),
    .pixels_checked (checked_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Output side: random stalls, plus one long hold-off when requested.
  initial begin : receiver
    int stall_left;
    bit stall_taken;
    stall_left = 0;
    stall_taken = 0;
    pix.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req && !stall_taken) begin
        stall_left = 300;
        stall_taken = 1;
      end
      if (stall_left > 0) begin
        stall_left--;
        pix.ready <= 1'b0;
      end else begin
        pix.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (lay.valid && lay.ready) || (pix.valid && pix.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("No handshake for %0d cycles, %0d pixel words outstanding.",
             QUIET_LIMIT, pending_count);
    $display("tb_threshold_layer_compositor: done, errors");
    $finish;
  end

  task automatic put_layer(input logic [VAL_BITS-1:0] s, input logic p,
                           input logic [VAL_BITS-1:0] mx, input logic last,
                           input logic fe);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle) gap++;
    @(negedge clk);
    if (gap > 0) begin
      lay.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    lay.valid = 1'b1;
    lay.sample = s;
    lay.present = p;
    lay.layer_max = mx;
    lay.last_layer = last;
    lay.frame_end = fe;
    do @(posedge clk); while (!lay.ready);
    words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Waits until every expected pixel word is out and the back end has gone quiet.
  task automatic settle();
    @(negedge clk);
    lay.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_pixel();
    int             n;
    int             r;
    logic           fe;
    logic [VAL_BITS-1:0] mx;
    logic [VAL_BITS-1:0] s;
    n = $urandom_range(1, 5);
    fe = (frame_left == 1);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      mx = (r == 0) ? 16'd0 : (r < 8) ? 16'($urandom_range(1, 65535))
                                      : 16'($urandom_range(1, 300));
      r = $urandom_range(0, 9);
      s = (r < 7) ? 16'($urandom_range(0, mx)) : (r < 9) ? 16'($urandom_range(0, 65535))
                                                         : mx + 16'($urandom_range(0, 3));
      put_layer(s, $urandom_range(0, 9) < 8, mx, i == n - 1, fe);
    end
    frame_left = (frame_left == 1) ? $urandom_range(1, 6) : frame_left - 1;
    pixel_open = 0;
  endtask

  initial begin : stimulus
    logic [THR_BITS-1:0] thr_set[6];
    logic [VAL_BITS-1:0] max_set[6];
    logic                last;
    rst = 1'b1;
    lay.valid = 1'b0;
    lay.sample = '0;
    lay.present = 1'b0;
    lay.layer_max = '0;
    lay.last_layer = 1'b0;
    lay.frame_end = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_THRESHOLD;
    cfg_ch.data = '0;
    send_idle = 0;
    recv_idle = 0;
    words_sent = 0;
    frame_left = 3;
    pixel_open = 0;
    stall_req = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words under the reset settings.
    put_layer(16'd0, 1, 16'd1, 1, 0);
    put_layer(16'd65535, 1, 16'd65535, 1, 1);
    put_layer(16'd0, 0, 16'd5, 1, 0);
    put_layer(16'd10, 1, 16'd100, 0, 0);
    put_layer(16'd99, 1, 16'd100, 1, 0);
    put_layer(16'd0, 0, 16'd7, 0, 0);
    put_layer(16'd80, 1, 16'd100, 0, 0);
    put_layer(16'd200, 1, 16'd100, 1, 0);
    put_layer(16'd0, 1, 16'd0, 0, 0);
    put_layer(16'd3, 1, 16'd0, 1, 0);
    put_layer(16'd49999, 1, 16'd65535, 0, 0);
    put_layer(16'd1, 1, 16'd2, 1, 0);
    put_layer(16'd32767, 1, 16'd65535, 0, 1);
    put_layer(16'd4, 0, 16'd1, 1, 1);
    settle();
    write_reg(REG_THRESHOLD, 17'd131071);
    write_reg(REG_OUTPUT_MAX, 17'd65535);
    put_layer(16'd100, 1, 16'd100, 1, 0);
    put_layer(16'd101, 1, 16'd100, 1, 0);
    put_layer(16'd65535, 1, 16'd1, 1, 1);
    settle();
    write_reg(REG_THRESHOLD, 17'd0);
    write_reg(REG_OUTPUT_MAX, 17'd0);
    put_layer(16'd0, 1, 16'd1, 1, 0);
    put_layer(16'd0, 0, 16'd1, 1, 1);

    thr_set = '{17'd32768, 17'd65536, 17'd0, 17'd131071,
                17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071))};
    max_set = '{16'd255, 16'd65535, 16'd1, 16'($urandom_range(1, 65535)),
                16'd0, 16'($urandom_range(1, 65535))};
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      write_reg(REG_THRESHOLD, thr_set[ph]);
      write_reg(REG_OUTPUT_MAX, {1'b0, max_set[ph]});
      send_idle = (ph < 2) ? 9 : (ph < 4) ? 75 : 0;
      recv_idle = (ph < 2) ? 75 : (ph < 4) ? 9 : 0;
      if (ph == 4) begin
        stall_req = 1;
      end
      words_sent = 0;
      while (words_sent < PHASE_WORDS) begin
        if ($urandom_range(0, 9) == 0) begin
          last = 1'($urandom_range(0, 1));
          put_layer(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                    16'($urandom_range(0, 65535)), last, 1'($urandom_range(0, 1)));
          pixel_open = !last;
        end else begin
          random_pixel();
        end
      end
      if (pixel_open) begin
        put_layer(16'($urandom_range(0, 65535)), 1, 16'($urandom_range(1, 65535)), 1, 1);
        pixel_open = 0;
      end
    end
    settle();

    $display("Checked %0d directed and %0d random pixel words, %0d errors.",
             13, checked_count - 13, err_count);
    $display("Ran six register settings, three idle patterns and one long output stall.");
    if (err_count == 0 && pending_count == 0) begin
      $display("tb_threshold_layer_compositor: done, clean");
    end else begin
      $display("tb_threshold_layer_compositor: done, errors");
    end
    $finish;
  end

endmodule
